FILE: src/mpc_pkg.sv
// Shared types and constants for the multichannel pulse counter.
// Used by the top level and the port checker; no dependencies.
package mpc_pkg;

  // Channel slots on the ports, and how many of them are served.
  localparam int NUM_CH   = 4;
  localparam int CHANNELS = 4;

  localparam int COUNT_W = 14;
  localparam int LOCK_W  = 10;
  localparam int STEP_W  = 7;
  localparam int TIME_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 14'd9999;
  localparam logic [LOCK_W-1:0]  LOCK_RESET   = 10'd10;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 7'd1;

  // APB register file
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_CH0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_CH1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_CH2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_CH3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_CH0    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEP_CH1    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STEP_CH2    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_STEP_CH3    = 3'd7;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NUM_CH-1:0] levels;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        clear_channel;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_ch0;
    logic [COUNT_W-1:0] count_ch1;
    logic [COUNT_W-1:0] count_ch2;
    logic [COUNT_W-1:0] count_ch3;
    logic [NUM_CH-1:0]  counted_mask;
  } result_t;

endpackage

FILE: src/multichannel_pulse_counter.sv
// Multichannel pulse counter top level with its APB registers; depends on mpc_pkg.
// Result path: an item passes through the hold register, then the result register,
//   before result_valid rises.
// Throughput: one item per cycle, set by the combinational per-channel update
//   (32-bit elapsed subtract and compare, 15-bit add and saturate); stalls on result_ready.
// Reset (rst, synchronous, high): pipeline empty, state zero, lockouts 10 ms, steps 1.
module multichannel_pulse_counter (
  input  logic                       clk,
  input  logic                       rst,
  // sample / clear items
  input  logic                       item_valid,
  output logic                       item_ready,
  input  mpc_pkg::item_t             item,
  // results, one per item
  output logic                       result_valid,
  input  logic                       result_ready,
  output mpc_pkg::result_t           result,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpc_pkg::ADDR_W-1:0] paddr,
  input  logic [mpc_pkg::DATA_W-1:0] pwdata,
  output logic [mpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mpc_pkg::LOCK_W-1:0] lockout [mpc_pkg::NUM_CH];
  logic [mpc_pkg::STEP_W-1:0] step    [mpc_pkg::NUM_CH];

  logic                          cfg_write;
  logic [mpc_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // word addressed: index sits above the byte offset
  assign reg_idx   = paddr[mpc_pkg::REG_IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < mpc_pkg::NUM_CH; n++) begin
        lockout[n] <= mpc_pkg::LOCK_RESET;
        step[n]    <= mpc_pkg::STEP_RESET;
      end
    end else if (cfg_write) begin
      case (reg_idx)
        mpc_pkg::REG_LOCKOUT_CH0: lockout[0] <= pwdata[mpc_pkg::LOCK_W-1:0];
        mpc_pkg::REG_LOCKOUT_CH1: lockout[1] <= pwdata[mpc_pkg::LOCK_W-1:0];
        mpc_pkg::REG_LOCKOUT_CH2: lockout[2] <= pwdata[mpc_pkg::LOCK_W-1:0];
        mpc_pkg::REG_LOCKOUT_CH3: lockout[3] <= pwdata[mpc_pkg::LOCK_W-1:0];
        mpc_pkg::REG_STEP_CH0:    step[0]    <= pwdata[mpc_pkg::STEP_W-1:0];
        mpc_pkg::REG_STEP_CH1:    step[1]    <= pwdata[mpc_pkg::STEP_W-1:0];
        mpc_pkg::REG_STEP_CH2:    step[2]    <= pwdata[mpc_pkg::STEP_W-1:0];
        mpc_pkg::REG_STEP_CH3:    step[3]    <= pwdata[mpc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back is combinational; APB samples it in the access phase
  always_comb begin
    prdata = '0;
    case (reg_idx)
      mpc_pkg::REG_LOCKOUT_CH0: prdata = mpc_pkg::DATA_W'(lockout[0]);
      mpc_pkg::REG_LOCKOUT_CH1: prdata = mpc_pkg::DATA_W'(lockout[1]);
      mpc_pkg::REG_LOCKOUT_CH2: prdata = mpc_pkg::DATA_W'(lockout[2]);
      mpc_pkg::REG_LOCKOUT_CH3: prdata = mpc_pkg::DATA_W'(lockout[3]);
      mpc_pkg::REG_STEP_CH0:    prdata = mpc_pkg::DATA_W'(step[0]);
      mpc_pkg::REG_STEP_CH1:    prdata = mpc_pkg::DATA_W'(step[1]);
      mpc_pkg::REG_STEP_CH2:    prdata = mpc_pkg::DATA_W'(step[2]);
      mpc_pkg::REG_STEP_CH3:    prdata = mpc_pkg::DATA_W'(step[3]);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: hold register -> result register
  // ---------------------------------------------------------------------------
  // The hold stage moves on whenever the result register is empty or its
  // contents are being transferred out, so a new item is taken every cycle
  // unless the output side stalls.
  mpc_pkg::item_t item_hold;
  logic           hold_valid;
  logic           advance;

  assign advance    = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_hold <= item;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel state and per-item update
  // ---------------------------------------------------------------------------
  logic [mpc_pkg::NUM_CH-1:0]  prev_levels;
  logic [mpc_pkg::TIME_W-1:0]  last_time [mpc_pkg::NUM_CH];
  logic [mpc_pkg::COUNT_W-1:0] count     [mpc_pkg::NUM_CH];

  logic [mpc_pkg::NUM_CH-1:0]  prev_levels_next;
  logic [mpc_pkg::TIME_W-1:0]  last_time_next [mpc_pkg::NUM_CH];
  logic [mpc_pkg::COUNT_W-1:0] count_next     [mpc_pkg::NUM_CH];
  logic [mpc_pkg::NUM_CH-1:0]  mask;
  logic [mpc_pkg::TIME_W-1:0]  elapsed [mpc_pkg::NUM_CH];
  logic [mpc_pkg::COUNT_W:0]   sum     [mpc_pkg::NUM_CH];

  // Channels work independently: falling edge = high last sample, low now.
  // Elapsed time wraps mod 2^32, so a plain subtract gives the right gap.
  always_comb begin
    prev_levels_next = prev_levels;
    mask             = '0;
    for (int n = 0; n < mpc_pkg::NUM_CH; n++) begin
      last_time_next[n] = last_time[n];
      count_next[n]     = count[n];
      elapsed[n]        = item_hold.now_ms - last_time[n];
      sum[n]            = {1'b0, count[n]} + (mpc_pkg::COUNT_W+1)'(step[n]);
    end
    if (item_hold.kind == mpc_pkg::KIND_CLEAR) begin
      // clear leaves levels and edge times alone
      for (int n = 0; n < mpc_pkg::NUM_CH; n++) begin
        if (n < mpc_pkg::CHANNELS && item_hold.clear_channel == 2'(n)) begin
          count_next[n] = '0;
        end
      end
    end else begin
      for (int n = 0; n < mpc_pkg::NUM_CH; n++) begin
        if (n < mpc_pkg::CHANNELS && prev_levels[n] && !item_hold.levels[n] &&
            elapsed[n] >= mpc_pkg::TIME_W'(lockout[n])) begin
          mask[n]           = 1'b1;
          last_time_next[n] = item_hold.now_ms;
          if (sum[n] > (mpc_pkg::COUNT_W+1)'(mpc_pkg::COUNT_LIMIT)) begin
            count_next[n] = mpc_pkg::COUNT_LIMIT;
          end else begin
            count_next[n] = sum[n][mpc_pkg::COUNT_W-1:0];
          end
        end
        // unserved channels never record a level
        prev_levels_next[n] = (n < mpc_pkg::CHANNELS) ? item_hold.levels[n] : 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      for (int n = 0; n < mpc_pkg::NUM_CH; n++) begin
        last_time[n] <= '0;
        count[n]     <= '0;
      end
    end else if (advance) begin
      prev_levels <= prev_levels_next;
      for (int n = 0; n < mpc_pkg::NUM_CH; n++) begin
        last_time[n] <= last_time_next[n];
        count[n]     <= count_next[n];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.count_ch0    <= count_next[0];
      result.count_ch1    <= count_next[1];
      result.count_ch2    <= count_next[2];
      result.count_ch3    <= count_next[3];
      result.counted_mask <= mask;
    end
  end

endmodule

FILE: src/mpc_checker.sv
// Port-level checker for the multichannel pulse counter, bound to the top level.
// Depends on mpc_pkg.
module mpc_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input mpc_pkg::result_t result,
  input logic             pready
);

  // a stalled result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // counts never pass the limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.count_ch0 <= mpc_pkg::COUNT_LIMIT &&
                     result.count_ch1 <= mpc_pkg::COUNT_LIMIT &&
                     result.count_ch2 <= mpc_pkg::COUNT_LIMIT &&
                     result.count_ch3 <= mpc_pkg::COUNT_LIMIT)
    else $error("count above limit");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // an empty pipeline always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid && $past(!item_valid) && !$past(rst) |-> item_ready)
    else $error("input stalled with empty pipeline");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind multichannel_pulse_counter mpc_checker u_mpc_checker (.*);
